@@ design/bit_vector_with_byte_pack_macros.svh @@
// assertion macros for the bit vector with byte pack block
// used by bit_vector_with_byte_pack.sv; expects a clock named clk and reset named rst
`ifndef BIT_VECTOR_WITH_BYTE_PACK_MACROS_SVH
`define BIT_VECTOR_WITH_BYTE_PACK_MACROS_SVH

// expression must hold at every clock edge outside reset
`define BVBP_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("bvbp invariant violated");

// antecedent implies consequent property outside reset
`define BVBP_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvbp implication violated");

`endif

@@ design/bvbp_pkg.sv @@
// shared constants and helper functions for the bit vector with byte pack block
// no dependencies
package bvbp_pkg;

  localparam int unsigned BVBP_MAX_BITS = 4096;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned BIDX_W  = 12;
  localparam int unsigned YIDX_W  = 9;
  localparam int unsigned ELEN_W  = 10;
  localparam int unsigned SIZE_RESET = 4096;

  // operation codes
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_WRITE  = 3'd1;
  localparam logic [2:0] OP_TEST   = 3'd2;
  localparam logic [2:0] OP_IMPORT = 3'd3;
  localparam logic [2:0] OP_EXPORT = 3'd4;

  // register index of size_bits
  localparam logic REG_SIZE = 1'b0;

  typedef logic [SIZE_W-1:0] count_t;

  function automatic logic [3:0] pop8(input logic [7:0] v);
    logic [3:0] c;
    c = 4'd0;
    for (int k = 0; k < 8; k++) begin
      c = c + 4'(v[k]);
    end
    return c;
  endfunction

  // bits of byte widx that lie inside the size, msb-first
  function automatic logic [7:0] range_mask(input logic [YIDX_W-1:0] widx,
                                            input logic [SIZE_W-1:0] sz);
    logic [SIZE_W-1:0] base;
    logic [SIZE_W-1:0] v;
    base = {1'b0, widx, 3'b000};
    v    = sz - base;
    if (base >= sz) begin
      return 8'h00;
    end else if (v >= SIZE_W'(8)) begin
      return 8'hFF;
    end else begin
      return 8'hFF << (4'd8 - {1'b0, v[2:0]});
    end
  endfunction

endpackage

@@ design/bit_vector_with_byte_pack.sv @@
// bit vector with msb-first byte packing, one memory of packed bytes and a running count
// depends on bvbp_pkg and bit_vector_with_byte_pack_macros.svh
`include "bit_vector_with_byte_pack_macros.svh"

// Bit vector of up to MAX_BITS bits, stored as (MAX_BITS+7)/8 packed bytes in one
// synchronous memory. Vector bit 8*i+k sits at bit 7-k of byte i. An operation is
// taken when start is high and busy is low; its result passes the modify stage and
// the result register, is on the result ports for one cycle with done high, and must
// be taken then: there is no back-pressure. Write bit, test bit, import byte and
// export byte go at one per cycle while busy is low: each reads one memory byte, write
// bit and import byte write it back, and a write made the cycle before is forwarded
// to the next read of the same byte. Clear all and a write of size_bits both zero
// the memory with a sweep of one byte per cycle, during which busy is high; the
// sweep also runs right after reset. Busy is also high while clear all is in its
// modify stage. The user must write the size register, at byte address 0 of the
// config port, only while no operation is in flight; the block does not enforce it.
module bit_vector_with_byte_pack
  import bvbp_pkg::*;
#(
  parameter int unsigned MAX_BITS = BVBP_MAX_BITS
) (
  input  logic              clk,
  input  logic              rst,
  // operation transfer
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        op,
  input  logic [BIDX_W-1:0] bit_index,
  input  logic              flag,
  input  logic [YIDX_W-1:0] byte_index,
  input  logic [7:0]        byte_value,
  input  logic              last_byte,
  // result, one cycle wide
  output logic              done,
  output logic              bit_value,
  output logic              error,
  output logic [7:0]        read_byte,
  output logic [ELEN_W-1:0] export_len,
  output logic [SIZE_W-1:0] set_count,
  output logic              all_set,
  output logic              none_set,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DEPTH = (MAX_BITS + 7) / 8;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // packed byte memory, one write and one registered read per cycle
  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;

  // config
  logic [SIZE_W-1:0] size_bits;
  logic [SIZE_W-1:0] eff;
  logic              cfg_wr;

  // clearing sweep
  logic          sweeping;
  logic [AW-1:0] sweep_addr;

  // running count of set bits
  count_t ones_count;

  // operation in its modify cycle
  logic              s1_valid;
  logic [2:0]        s1_op;
  logic [BIDX_W-1:0] s1_bidx;
  logic              s1_flag;
  logic [YIDX_W-1:0] s1_yidx;
  logic [7:0]        s1_bval;
  logic              s1_last;

  // last item write, for forwarding into the next read
  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  logic [7:0]    fwd_data;

  logic              accept;
  logic [YIDX_W-1:0] rd_widx;

  logic [YIDX_W-1:0] s1_widx;
  logic              s1_in_store;
  logic              s1_in_bit;
  logic              s1_hit;
  logic [7:0]        old_word;
  logic [7:0]        bit_mask;
  logic [7:0]        byte_mask;
  logic [7:0]        new_word;
  logic              s1_wr;
  logic              s1_clear;
  logic              err_c;
  logic              bit_c;
  logic [7:0]        byte_c;
  count_t            cnt_c;
  logic [SIZE_W:0]   elen_sum;
  logic [ELEN_W-1:0] elen_c;

  // ---------------------------------------------------------------------------
  // config register, write on the access phase of an apb transfer
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits <= SIZE_W'(SIZE_RESET);
    end else if (cfg_wr) begin
      size_bits <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_SIZE) begin
      prdata = 32'(size_bits);
    end
  end

  // size saturates at the store capacity
  assign eff = (32'(size_bits) > MAX_BITS) ? SIZE_W'(MAX_BITS) : size_bits;

  // packed length, ceiling of size over eight, saturating at the port width
  assign elen_sum = {1'b0, eff} + (SIZE_W + 1)'(7);
  always_comb begin
    if (elen_sum[SIZE_W:3] > (SIZE_W - 2)'({ELEN_W{1'b1}})) begin
      elen_c = {ELEN_W{1'b1}};
    end else begin
      elen_c = ELEN_W'(elen_sum[SIZE_W:3]);
    end
  end

  // ---------------------------------------------------------------------------
  // accept and read issue
  // ---------------------------------------------------------------------------
  // busy through the sweep and through the modify cycle of a clear all that kicks it off
  assign busy   = sweeping || (s1_valid && (s1_op == OP_CLEAR));
  assign accept = start && !busy;

  // write and test address by bit position, import and export by byte position
  assign rd_widx = ((op == OP_WRITE) || (op == OP_TEST)) ? bit_index[BIDX_W-1:3] : byte_index;
  assign raddr   = AW'(rd_widx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= op;
      s1_bidx <= bit_index;
      s1_flag <= flag;
      s1_yidx <= byte_index;
      s1_bval <= byte_value;
      s1_last <= last_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // modify cycle: read data arrives, new byte and count are formed
  // ---------------------------------------------------------------------------
  assign s1_widx = ((s1_op == OP_WRITE) || (s1_op == OP_TEST)) ? s1_bidx[BIDX_W-1:3] : s1_yidx;
  assign s1_in_store = (32'(s1_widx) < DEPTH);
  assign s1_in_bit   = ({1'b0, s1_bidx} < eff);
  // the write of the previous item lands in the same edge as this read
  assign s1_hit   = fwd_valid && (fwd_addr == AW'(s1_widx));
  assign old_word = s1_hit ? fwd_data : rdata;

  assign bit_mask  = 8'h80 >> s1_bidx[2:0];
  assign byte_mask = range_mask(s1_yidx, eff);

  always_comb begin
    new_word = old_word;
    s1_wr    = 1'b0;
    s1_clear = 1'b0;
    err_c    = 1'b0;
    bit_c    = 1'b0;
    byte_c   = 8'h00;
    unique case (s1_op)
      OP_CLEAR: begin
        s1_clear = 1'b1;
      end
      OP_WRITE: begin
        if (!s1_in_bit) begin
          err_c = 1'b1;
        end else begin
          new_word = s1_flag ? (old_word | bit_mask) : (old_word & ~bit_mask);
          s1_wr    = 1'b1;
        end
      end
      OP_TEST: begin
        bit_c = s1_in_bit && ((old_word & bit_mask) != 8'h00);
      end
      OP_IMPORT: begin
        // masked bits past the size are dropped, short run still writes its byte
        new_word = s1_bval & byte_mask;
        s1_wr    = s1_in_store;
        err_c    = s1_last &&
                   ((SIZE_W'({s1_yidx, 3'b000}) + SIZE_W'(8)) < eff);
      end
      OP_EXPORT: begin
        // mask is zero for bytes past the size, which covers bytes past the store
        byte_c = old_word & byte_mask;
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (s1_clear) begin
      cnt_c = '0;
    end else if (s1_wr) begin
      cnt_c = ones_count + count_t'(pop8(new_word)) - count_t'(pop8(old_word));
    end else begin
      cnt_c = ones_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ones_count <= '0;
    end else if (cfg_wr) begin
      ones_count <= '0;
    end else if (s1_valid) begin
      ones_count <= cnt_c;
    end
  end

  // ---------------------------------------------------------------------------
  // clearing sweep after reset, clear all and a size write
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (cfg_wr || (s1_valid && s1_clear)) begin
      sweeping   <= 1'b1;
      sweep_addr <= '0;
    end else if (sweeping) begin
      if (sweep_addr == AW'(DEPTH - 1)) begin
        sweeping <= 1'b0;
      end else begin
        sweep_addr <= sweep_addr + AW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // memory write port and forwarding register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (sweeping) begin
      we    = 1'b1;
      waddr = sweep_addr;
      wdata = 8'h00;
    end else begin
      we    = s1_valid && s1_wr;
      waddr = AW'(s1_widx);
      wdata = new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= !sweeping && s1_valid && s1_wr;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= AW'(s1_widx);
    fwd_data <= new_word;
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      bit_value  <= bit_c;
      error      <= err_c;
      read_byte  <= byte_c;
      export_len <= elen_c;
      set_count  <= cnt_c;
      all_set    <= (cnt_c == eff);
      none_set   <= (cnt_c == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `BVBP_ASSERT_IMPLY(a_result_follows, accept, ##2 done)
  `BVBP_ASSERT_IMPLY(a_count_in_size, done, set_count <= eff)
  `BVBP_ASSERT_ALWAYS(a_no_write_in_sweep, !(sweeping && s1_valid && s1_wr))

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for bit_vector_with_byte_pack: directed and random operations,
// size register changes over the config port, results checked against a bit-exact tracker
// depends on bvbp_pkg and the bit_vector_with_byte_pack rtl
`timescale 1ns / 100ps

import bvbp_pkg::*;

typedef struct packed {
  logic [2:0]        op;
  logic [BIDX_W-1:0] bit_index;
  logic              flag;
  logic [YIDX_W-1:0] byte_index;
  logic [7:0]        byte_value;
  logic              last_byte;
} bv_op_t;

typedef struct packed {
  logic              bit_value;
  logic              error;
  logic [7:0]        read_byte;
  logic [ELEN_W-1:0] export_len;
  count_t            set_count;
  logic              all_set;
  logic              none_set;
} bv_result_t;

// tracks the packed store, valid bits and count, and holds the results still owed
class bitfield_tracker;
  localparam int unsigned STORE_BYTES = (BVBP_MAX_BITS + 7) / 8;

  bit [7:0]         packed_bytes[STORE_BYTES];
  bit               byte_live[STORE_BYTES];
  count_t           ones;
  logic [SIZE_W-1:0] size_reg;
  bv_result_t       owed_results[$];
  int unsigned      fail_count;
  int unsigned      result_seq;

  function new();
    foreach (packed_bytes[i]) begin
      packed_bytes[i] = 8'h00;
      byte_live[i]    = 1'b0;
    end
    ones       = '0;
    size_reg   = SIZE_W'(SIZE_RESET);
    fail_count = 0;
    result_seq = 0;
  endfunction

  function int unsigned eff_size();
    return (size_reg > BVBP_MAX_BITS) ? BVBP_MAX_BITS : int'(size_reg);
  endfunction

  function int unsigned pending();
    return owed_results.size();
  endfunction

  // a byte never written since the last clear reads as zero
  function logic [7:0] fetch(int unsigned widx);
    if (widx >= STORE_BYTES || !byte_live[widx]) return 8'h00;
    return packed_bytes[widx];
  endfunction

  function void store(int unsigned widx, logic [7:0] v);
    if (widx >= STORE_BYTES) return;
    packed_bytes[widx] = v;
    byte_live[widx]    = 1'b1;
  endfunction

  // bits of byte widx inside the size, lowest vector bit in the msb
  function logic [7:0] live_mask(int unsigned widx);
    int unsigned sz;
    int unsigned base;
    sz   = eff_size();
    base = widx * 8;
    if (base >= sz) return 8'h00;
    if (sz - base >= 8) return 8'hFF;
    return 8'hFF << (8 - (sz - base));
  endfunction

  function void wipe();
    foreach (byte_live[i]) byte_live[i] = 1'b0;
    ones = '0;
  endfunction

  // a size write also clears the vector
  function void apply_size(logic [31:0] v);
    size_reg = v[SIZE_W-1:0];
    wipe();
  endfunction

  // work out the result of one accepted operation and queue it
  function void note_op(bv_op_t it);
    bv_result_t  r;
    int unsigned sz;
    int unsigned widx;
    logic [7:0]  old_v;
    logic [7:0]  new_v;
    logic [7:0]  bit_m;
    int          cnt;
    sz   = eff_size();
    r    = '0;
    cnt  = int'(ones);
    case (it.op)
      OP_CLEAR: begin
        wipe();
        cnt = 0;
      end
      OP_WRITE: begin
        if (it.bit_index >= sz) begin
          r.error = 1'b1;
        end else begin
          widx  = it.bit_index >> 3;
          bit_m = 8'h80 >> it.bit_index[2:0];
          old_v = fetch(widx);
          new_v = it.flag ? (old_v | bit_m) : (old_v & ~bit_m);
          cnt   = cnt + $countones(new_v) - $countones(old_v);
          store(widx, new_v);
        end
      end
      OP_TEST: begin
        if (it.bit_index < sz) begin
          old_v       = fetch(it.bit_index >> 3);
          r.bit_value = old_v[7 - it.bit_index[2:0]];
        end
      end
      OP_IMPORT: begin
        widx  = it.byte_index;
        old_v = fetch(widx);
        new_v = it.byte_value & live_mask(widx);
        cnt   = cnt + $countones(new_v) - $countones(old_v);
        store(widx, new_v);
        // short run: the last byte ends before the size does
        if (it.last_byte && (widx + 1) * 8 < sz) r.error = 1'b1;
      end
      OP_EXPORT: begin
        r.read_byte = fetch(it.byte_index) & live_mask(it.byte_index);
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    ones        = count_t'(cnt);
    r.export_len = ELEN_W'((sz + 7) / 8);
    r.set_count  = ones;
    r.all_set    = (int'(ones) == sz);
    r.none_set   = (ones == '0);
    owed_results.push_back(r);
  endfunction

  task report_mismatch(string what, longint unsigned want, longint unsigned got);
    fail_count++;
    $display("[%0t] result %0d: %s expected %0h got %0h", $time, result_seq, what, want, got);
  endtask

  task check_result(bv_result_t got);
    bv_result_t want;
    result_seq++;
    if (owed_results.size() == 0) begin
      report_mismatch("unexpected result, nothing owed", 0, got);
    end else begin
      want = owed_results.pop_front();
      if (got.bit_value !== want.bit_value)
        report_mismatch("bit_value", want.bit_value, got.bit_value);
      if (got.error !== want.error)
        report_mismatch("error", want.error, got.error);
      if (got.read_byte !== want.read_byte)
        report_mismatch("read_byte", want.read_byte, got.read_byte);
      if (got.export_len !== want.export_len)
        report_mismatch("export_len", want.export_len, got.export_len);
      if (got.set_count !== want.set_count)
        report_mismatch("set_count", want.set_count, got.set_count);
      if (got.all_set !== want.all_set)
        report_mismatch("all_set", want.all_set, got.all_set);
      if (got.none_set !== want.none_set)
        report_mismatch("none_set", want.none_set, got.none_set);
    end
  endtask
endclass

module testbench;

  // codes 5 to 7 have no operation behind them
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_COUNT  = 10;
  localparam int unsigned PHASE_ITEMS  = 63;
  localparam int unsigned SETTLE_TICKS = 8;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [2:0]        op;
  logic [BIDX_W-1:0] bit_index;
  logic              flag;
  logic [YIDX_W-1:0] byte_index;
  logic [7:0]        byte_value;
  logic              last_byte;
  logic              done;
  logic              bit_value;
  logic              error;
  logic [7:0]        read_byte;
  logic [ELEN_W-1:0] export_len;
  logic [SIZE_W-1:0] set_count;
  logic              all_set;
  logic              none_set;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  bitfield_tracker tracker;
  int unsigned     cycle_count;
  int unsigned     items_sent;

  // size per random phase: saturation, odd sizes, one bit, full and near-full
  int unsigned phase_size[PHASE_COUNT] = '{8191, 37, 1, 200, 4096, 64, 5000, 8, 4095, 4096};
  // sender idle percentage, cycled through the phases
  int unsigned idle_pct[3] = '{0, 77, 21};

  bit_vector_with_byte_pack dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .bit_index  (bit_index),
    .flag       (flag),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .done       (done),
    .bit_value  (bit_value),
    .error      (error),
    .read_byte  (read_byte),
    .export_len (export_len),
    .set_count  (set_count),
    .all_set    (all_set),
    .none_set   (none_set),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result monitor: a result lives for one cycle, so it is taken on every done
  always @(posedge clk) begin
    if (!rst && done) begin
      tracker.check_result('{bit_value, error, read_byte, export_len, set_count,
                             all_set, none_set});
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               tracker.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bv_op_t mk(logic [2:0] o, int unsigned bidx, bit f, int unsigned yidx,
                                logic [7:0] v, bit last);
    bv_op_t it;
    it.op         = o;
    it.bit_index  = BIDX_W'(bidx);
    it.flag       = f;
    it.byte_index = YIDX_W'(yidx);
    it.byte_value = v;
    it.last_byte  = last;
    return it;
  endfunction

  // one operation transfer: fields go out at the falling edge, start stays high
  // until a rising edge with busy low takes it
  task issue_op(bv_op_t it);
    @(negedge clk);
    start      <= 1'b1;
    op         <= it.op;
    bit_index  <= it.bit_index;
    flag       <= it.flag;
    byte_index <= it.byte_index;
    byte_value <= it.byte_value;
    last_byte  <= it.last_byte;
    do @(posedge clk); while (busy);
    tracker.note_op(it);
    items_sent++;
  endtask

  task maybe_idle(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      repeat ($urandom_range(4, 1)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
  endtask

  // hold the sender off until every owed result is in and the block is free
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (tracker.pending() != 0 || busy) @(posedge clk);
  endtask

  task write_size(logic [31:0] v);
    drain();
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'({REG_SIZE, 2'b00});
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.apply_size(v);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // bit or byte index, mostly near the live part of the vector
  function automatic int unsigned near_index(int unsigned span, int unsigned top);
    if (span > 0 && $urandom_range(99) < 70) begin
      return $urandom_range((span + 3 > top) ? top : span + 3, 0);
    end
    return $urandom_range(top, 0);
  endfunction

  function automatic bv_op_t random_op(int unsigned sz);
    bv_op_t      it;
    int unsigned r;
    it.op         = OP_TEST;
    it.bit_index  = BIDX_W'($urandom());
    it.flag       = 1'($urandom_range(1));
    it.byte_index = YIDX_W'($urandom());
    it.byte_value = 8'($urandom());
    it.last_byte  = ($urandom_range(99) < 20);
    r = $urandom_range(99);
    if (r < 3)       it.op = OP_CLEAR;
    else if (r < 38) it.op = OP_WRITE;
    else if (r < 58) it.op = OP_TEST;
    else if (r < 78) it.op = OP_IMPORT;
    else if (r < 95) it.op = OP_EXPORT;
    else             it.op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    if (it.op == OP_WRITE || it.op == OP_TEST) begin
      it.bit_index = BIDX_W'(near_index(sz, BVBP_MAX_BITS - 1));
    end else begin
      it.byte_index = YIDX_W'(near_index((sz + 7) / 8, (BVBP_MAX_BITS / 8) - 1));
    end
    return it;
  endfunction

  // random phase: mostly single operations, with import runs from byte 0 and,
  // on small vectors, runs that set every bit so the all-set flag is reached
  task run_phase(int unsigned pct);
    int unsigned sz;
    int unsigned target;
    int unsigned full_len;
    int unsigned run_len;
    int unsigned r;
    bit          held;
    target = items_sent + PHASE_ITEMS;
    held   = 1'b0;
    while (items_sent < target) begin
      sz = tracker.eff_size();
      full_len = (sz + 7) / 8;
      r = $urandom_range(99);
      if (r < 8 && sz > 0) begin
        if (sz <= 256) begin
          run_len = ($urandom_range(3) == 0) ? $urandom_range(full_len, 1) : full_len;
        end else begin
          run_len = $urandom_range(12, 1);
        end
        for (int unsigned b = 0; b < run_len; b++) begin
          issue_op(mk(OP_IMPORT, $urandom(), 1'($urandom_range(1)), b,
                      ($urandom_range(1) == 1) ? 8'hFF : 8'($urandom()), b == run_len - 1));
          maybe_idle(pct);
        end
      end else if (r < 12 && sz > 0 && sz <= 64) begin
        for (int unsigned b = 0; b < sz; b++) begin
          issue_op(mk(OP_WRITE, b, 1'b1, $urandom(), 8'($urandom()),
                      1'($urandom_range(1))));
          maybe_idle(pct);
        end
      end else begin
        issue_op(random_op(sz));
        maybe_idle(pct);
      end
      // sender pause until everything owed has come back, once mid-phase and now and then
      if ((!held && items_sent >= target - PHASE_ITEMS / 2) || $urandom_range(99) == 0) begin
        held = 1'b1;
        drain();
      end
    end
  endtask

  initial begin
    tracker     = new();
    cycle_count = 0;
    items_sent  = 0;
    rst         = 1'b1;
    start       = 1'b0;
    op          = OP_CLEAR;
    bit_index   = '0;
    flag        = 1'b0;
    byte_index  = '0;
    byte_value  = 8'h00;
    last_byte   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, at the reset size: both ends of the vector and of the store
    issue_op(mk(OP_TEST,   0,    0, 0,   8'h00, 0));
    issue_op(mk(OP_WRITE,  0,    1, 0,   8'h00, 0));
    issue_op(mk(OP_WRITE,  4095, 1, 0,   8'h00, 0));
    issue_op(mk(OP_TEST,   4095, 0, 0,   8'h00, 0));
    issue_op(mk(OP_IMPORT, 0,    0, 0,   8'hFF, 0));
    // last byte of a full-length run: no error
    issue_op(mk(OP_IMPORT, 0,    0, 511, 8'h5A, 1));
    // run ends early: error, byte still stored
    issue_op(mk(OP_IMPORT, 0,    0, 3,   8'h81, 1));
    issue_op(mk(OP_EXPORT, 0,    0, 511, 8'h00, 0));
    issue_op(mk(OP_EXPORT, 0,    0, 3,   8'h00, 0));
    issue_op(mk(OP_WRITE,  0,    0, 0,   8'h00, 0));
    issue_op(mk(OP_RSVD_LO, 0,   0, 0,   8'h00, 0));
    issue_op(mk(OP_RSVD_HI, 0,   0, 0,   8'h00, 0));
    issue_op(mk(OP_CLEAR,  0,    0, 0,   8'h00, 0));
    issue_op(mk(OP_EXPORT, 0,    0, 0,   8'h00, 0));

    // empty vector: writes fail, imports drop everything, all-set and none-set both high
    write_size(32'd0);
    issue_op(mk(OP_WRITE,  0,    1, 0,   8'h00, 0));
    issue_op(mk(OP_IMPORT, 0,    0, 0,   8'hFF, 1));
    issue_op(mk(OP_TEST,   4095, 0, 0,   8'h00, 0));

    // size not a multiple of eight: partial last byte
    write_size(32'd13);
    issue_op(mk(OP_IMPORT, 0,    0, 1,   8'hFF, 1));
    issue_op(mk(OP_IMPORT, 0,    0, 0,   8'hFF, 1));
    issue_op(mk(OP_EXPORT, 0,    0, 1,   8'h00, 0));
    issue_op(mk(OP_WRITE,  13,   1, 0,   8'h00, 0));
    issue_op(mk(OP_WRITE,  12,   0, 0,   8'h00, 0));
    issue_op(mk(OP_TEST,   11,   0, 0,   8'h00, 0));
    issue_op(mk(OP_RSVD_LO + 3'd1, 0, 0, 0, 8'h00, 0));

    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      write_size(32'(phase_size[p]));
      run_phase(idle_pct[p % 3]);
    end

    drain();
    repeat (SETTLE_TICKS) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/bvbp_pkg.sv
design/bit_vector_with_byte_pack.sv
tb/sv/testbench.sv
